### sv/auflv_pkg.sv
// Shared types and constants for the H.264 access unit FLV tagger.
`timescale 1ns / 1ps
`default_nettype none
package auflv_pkg;

  localparam int unsigned POS_W = 24;
  localparam int unsigned LEN_W = 25;

  localparam logic [POS_W-1:0] POS_MAX        = 24'hFFFFFF;
  localparam logic [23:0]      BUF_SIZE_RESET = 24'h010000;
  localparam logic [31:0]      START_CODE     = 32'h0000_0001;

  localparam logic [4:0] NAL_SLICE = 5'h01;
  localparam logic [4:0] NAL_IDR   = 5'h05;
  localparam logic [4:0] NAL_SPS   = 5'h07;
  localparam logic [4:0] NAL_PPS   = 5'h08;

  localparam logic [3:0] FLAG_SPS = 4'h1;
  localparam logic [3:0] FLAG_PPS = 4'h2;
  localparam logic [3:0] FLAG_I   = 4'h4;
  localparam logic [3:0] FLAG_P   = 4'h8;

  localparam logic [7:0] FRAME_KEY   = 8'h17;
  localparam logic [7:0] FRAME_INTER = 8'h27;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_BIG   = 2'd2;

  // NAL unit currently open for length measurement
  typedef enum logic [2:0] {
    OPEN_NONE = 3'b001,
    OPEN_SPS  = 3'b010,
    OPEN_PPS  = 3'b100
  } open_kind_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [31:0]      prev;      // four bytes before the current one
    open_kind_t       open_kind;
    logic [3:0]       flags;
    logic             stopped;
    logic [POS_W-1:0] sps_start;
    logic [POS_W-1:0] sps_size;
    logic [POS_W-1:0] pps_start;
    logic [POS_W-1:0] pps_size;
    logic [POS_W-1:0] slice_start;
  } unit_t;

  localparam unit_t UNIT_CLEAR = '{
    pos: '0, prev: '0, open_kind: OPEN_NONE, flags: '0, stopped: 1'b0,
    sps_start: '0, sps_size: '0, pps_start: '0, pps_size: '0, slice_start: '0
  };

  typedef struct packed {
    logic [3:0]       kind_flags;
    logic [POS_W-1:0] sps_offset;
    logic [POS_W-1:0] sps_length;
    logic [POS_W-1:0] pps_offset;
    logic [POS_W-1:0] pps_length;
    logic [POS_W-1:0] slice_offset;
    logic [POS_W-1:0] slice_length;
    logic [23:0]      tag_data_size;
    logic [7:0]       frame_byte;
    logic [31:0]      relative_time;
    logic [LEN_W-1:0] packet_size;
    logic [1:0]       status;
  } tag_t;

endpackage
`default_nettype wire

### sv/auflv_if.sv
// Valid/ready channel interfaces for access unit bytes and tag descriptors.
`timescale 1ns / 1ps
`default_nettype none
interface auflv_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last;
  logic [31:0] time_stamp;

  modport source (output valid, data_byte, last, time_stamp, input ready);
  modport sink   (input valid, data_byte, last, time_stamp, output ready);
endinterface

interface auflv_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind_flags;
  logic [23:0] sps_offset;
  logic [23:0] sps_length;
  logic [23:0] pps_offset;
  logic [23:0] pps_length;
  logic [23:0] slice_offset;
  logic [23:0] slice_length;
  logic [23:0] tag_data_size;
  logic [7:0]  frame_byte;
  logic [31:0] relative_time;
  logic [24:0] packet_size;
  logic [1:0]  status;

  modport source (output valid, kind_flags, sps_offset, sps_length, pps_offset, pps_length,
                  slice_offset, slice_length, tag_data_size, frame_byte, relative_time,
                  packet_size, status, input ready);
  modport sink   (input valid, kind_flags, sps_offset, sps_length, pps_offset, pps_length,
                  slice_offset, slice_length, tag_data_size, frame_byte, relative_time,
                  packet_size, status, output ready);
endinterface
`default_nettype wire

### sv/auflv_scan.sv
// Per-byte start code scan, unit state and tag descriptor computation.
`timescale 1ns / 1ps
`default_nettype none
module auflv_scan import auflv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata,
  input  wire logic        acc,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last,
  input  wire logic [31:0] time_stamp,
  output logic             res_valid,
  output tag_t             res
);

  unit_t       unit_r, unit_nxt, upd;
  logic [23:0] buf_size_r;
  logic [31:0] base_r, base_nxt;
  logic        latched_r, latched_nxt;

  logic [4:0]       nal;
  logic             active, fast, is_start;
  logic [POS_W-1:0] p;
  logic [LEN_W-1:0] len;
  logic             short_unit, too_big, unit_ok, stand_alone;

  assign nal      = data_byte[4:0];
  assign p        = unit_r.pos - POS_W'(4);
  assign active   = !unit_r.stopped && (unit_r.pos >= POS_W'(4));
  assign fast     = active && (unit_r.pos == POS_W'(4)) && (nal == NAL_IDR || nal == NAL_SLICE);
  assign is_start = active && !fast && (unit_r.prev == START_CODE);

  // state after this byte is scanned
  always_comb begin
    upd      = unit_r;
    upd.prev = {unit_r.prev[23:0], data_byte};
    upd.pos  = (unit_r.pos == POS_MAX) ? unit_r.pos : unit_r.pos + POS_W'(1);
    if (fast) begin
      upd.flags       = (nal == NAL_IDR) ? FLAG_I : FLAG_P;
      upd.slice_start = '0;
      upd.stopped     = 1'b1;
    end else if (is_start) begin
      case (unit_r.open_kind)
        OPEN_SPS: upd.sps_size = p - unit_r.sps_start;
        OPEN_PPS: upd.pps_size = p - unit_r.pps_start;
        default: ;
      endcase
      upd.open_kind = OPEN_NONE;
      if (nal == NAL_SPS) begin
        upd.open_kind = OPEN_SPS;
        upd.sps_start = p;
        upd.flags     = unit_r.flags | FLAG_SPS;
      end else if (nal == NAL_PPS) begin
        upd.open_kind = OPEN_PPS;
        upd.pps_start = p;
        upd.flags     = unit_r.flags | FLAG_PPS;
      end else if (nal == NAL_IDR || nal == NAL_SLICE) begin
        upd.slice_start = p;
        upd.flags       = unit_r.flags | ((nal == NAL_IDR) ? FLAG_I : FLAG_P);
        upd.stopped     = 1'b1;
      end
    end
  end

  assign len         = {1'b0, unit_r.pos} + LEN_W'(1);
  assign short_unit  = len < LEN_W'(4);
  assign too_big     = ({1'b0, len} + 26'd5) > {2'b00, buf_size_r};
  assign unit_ok     = !short_unit && !too_big;
  assign stand_alone = |(upd.flags & (FLAG_I | FLAG_P));

  always_comb begin
    res = '0;
    if (short_unit) begin
      res.status = ST_SHORT;
    end else if (too_big) begin
      res.status = ST_BIG;
    end else begin
      res.kind_flags    = upd.flags;
      res.sps_offset    = upd.sps_start;
      res.sps_length    = upd.sps_size;
      res.pps_offset    = upd.pps_start;
      res.pps_length    = upd.pps_size;
      res.slice_offset  = stand_alone ? upd.slice_start : '0;
      res.slice_length  = stand_alone ? (len[POS_W-1:0] - upd.slice_start) : '0;
      res.tag_data_size = len[POS_W-1:0] + 24'd5;
      res.frame_byte    = |(upd.flags & FLAG_I) ? FRAME_KEY : FRAME_INTER;
      // first good unit defines time zero
      res.relative_time = time_stamp - (latched_r ? base_r : time_stamp);
      res.packet_size   = len + LEN_W'(20);
      res.status        = ST_OK;
    end
  end

  assign res_valid = acc && last;

  always_comb begin
    unit_nxt    = unit_r;
    base_nxt    = base_r;
    latched_nxt = latched_r;
    if (acc) begin
      unit_nxt = last ? UNIT_CLEAR : upd;
      if (last && unit_ok && !latched_r) begin
        base_nxt    = time_stamp;
        latched_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r     <= UNIT_CLEAR;
      buf_size_r <= BUF_SIZE_RESET;
      base_r     <= '0;
      latched_r  <= 1'b0;
    end else begin
      unit_r    <= unit_nxt;
      base_r    <= base_nxt;
      latched_r <= latched_nxt;
      if (cfg_we) begin
        buf_size_r <= cfg_wdata;
      end
    end
  end

endmodule
`default_nettype wire

### sv/auflv_skid.sv
// Two-entry output register for tag descriptors.
`timescale 1ns / 1ps
`default_nettype none
module auflv_skid import auflv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire tag_t push_data,
  output logic      room,
  output logic      out_valid,
  input  wire logic out_ready,
  output tag_t      out_data
);

  tag_t main_r, skid_r;
  logic main_valid_r, skid_valid_r;
  logic pop;

  assign pop       = main_valid_r && out_ready;
  assign room      = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (push && (!main_valid_r || pop)) begin
        main_valid_r <= 1'b1;
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end else if (pop) begin
        main_valid_r <= skid_valid_r;
        skid_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && (!main_valid_r || pop)) begin
      main_r <= push_data;
    end else if (push) begin
      skid_r <= push_data;
    end else if (pop && skid_valid_r) begin
      main_r <= skid_r;
    end
  end

endmodule
`default_nettype wire

### sv/h264_access_unit_flv_tagger_top.sv
// Top level of the H.264 access unit to FLV video tag descriptor block.
`timescale 1ns / 1ps
`default_nettype none
// Takes one access unit byte per cycle (in_ch, last byte marked); once the last byte
// is accepted, one tag descriptor is registered and shown on out_ch. Start code
// compare and unit counters update per accepted byte. Results pass through a two-entry
// output buffer, so bytes keep flowing while one descriptor waits; in_ch.ready drops
// only when both entries are full. buffer_size (cfg_wdata) resets to 65536. The user
// must write it with cfg_we only while idle; the block does not enforce this.
module h264_access_unit_flv_tagger_top import auflv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata,
  auflv_in_if.sink         in_ch,
  auflv_out_if.source      out_ch
);

  logic acc, res_valid, room;
  tag_t res, out_data;

  assign in_ch.ready = room;
  assign acc         = in_ch.valid && room;

  auflv_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .acc        (acc),
    .data_byte  (in_ch.data_byte),
    .last       (in_ch.last),
    .time_stamp (in_ch.time_stamp),
    .res_valid  (res_valid),
    .res        (res)
  );

  auflv_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.kind_flags    = out_data.kind_flags;
  assign out_ch.sps_offset    = out_data.sps_offset;
  assign out_ch.sps_length    = out_data.sps_length;
  assign out_ch.pps_offset    = out_data.pps_offset;
  assign out_ch.pps_length    = out_data.pps_length;
  assign out_ch.slice_offset  = out_data.slice_offset;
  assign out_ch.slice_length  = out_data.slice_length;
  assign out_ch.tag_data_size = out_data.tag_data_size;
  assign out_ch.frame_byte    = out_data.frame_byte;
  assign out_ch.relative_time = out_data.relative_time;
  assign out_ch.packet_size   = out_data.packet_size;
  assign out_ch.status        = out_data.status;

endmodule
`default_nettype wire

### sv/auflv_checker.sv
// Port-level assertions for the tagger top level, attached by bind.
`timescale 1ns / 1ps
`default_nettype none
module auflv_checker import auflv_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_kind_flags,
  input wire logic [23:0] out_tag_data_size,
  input wire logic [7:0]  out_frame_byte,
  input wire logic [24:0] out_packet_size,
  input wire logic [1:0]  out_status
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("descriptor valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("descriptor dropped while stalled");

  a_frame_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |->
      out_frame_byte == (out_kind_flags[2] ? FRAME_KEY : FRAME_INTER))
    else $error("frame byte does not match I flag");

  a_sizes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |->
      out_packet_size == {1'b0, out_tag_data_size} + 25'd15)
    else $error("packet size and tag data size disagree");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_SHORT || out_status == ST_BIG) |->
      out_kind_flags == 4'd0 && out_tag_data_size == 24'd0 && out_packet_size == 25'd0)
    else $error("error descriptor carries data");

endmodule

bind h264_access_unit_flv_tagger_top auflv_checker u_auflv_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_kind_flags    (out_ch.kind_flags),
  .out_tag_data_size (out_ch.tag_data_size),
  .out_frame_byte    (out_ch.frame_byte),
  .out_packet_size   (out_ch.packet_size),
  .out_status        (out_ch.status)
);
`default_nettype wire
